// ----- rtl/tcc_pkg.sv -----
// Shared types, widths and constants of the triangle cell classifier.
// Geometry width helpers are shared by tcc_geom and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // Fixed field widths
  localparam int SCREEN_W   = 10;
  localparam int ORIGIN_W   = 10;
  localparam int SPX_W      = 4;
  localparam int INV_W      = 16;
  localparam int TRI_W      = 13;
  localparam int SLOT_W     = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int TRI_MIN = -4096;
  localparam int TRI_MAX = 4095;

  // Pipeline stages
  localparam int NSTG     = 6;
  localparam int ST_IN    = 0;
  localparam int ST_PX    = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_CELL  = 3;
  localparam int ST_QUOT  = 4;
  localparam int ST_OUT   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_COL = 3'd0,
    REG_ORIGIN_ROW = 3'd1,
    REG_SPX_WIDTH  = 3'd2,
    REG_SPX_HEIGHT = 3'd3,
    REG_INV_EDGE   = 3'd4,
    REG_INV_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_col;
    logic [ORIGIN_W-1:0] origin_row;
    logic [SPX_W-1:0]    spx_width;
    logic [SPX_W-1:0]    spx_height;
    logic [INV_W-1:0]    inv_edge;
    logic [INV_W-1:0]    inv_height;
  } cfg_t;

  // Effective screen bits: the fields never carry more than SCREEN_W bits
  function automatic int eff_sb(input int sb);
    return (sb < SCREEN_W) ? sb : SCREEN_W;
  endfunction

  // Signed sub-pixel offset width
  function automatic int px_w(input int sb);
    return eff_sb(sb) + SPX_W + 1;
  endfunction

  // Signed product width, scale 2^F
  function automatic int b_w(input int sb);
    return eff_sb(sb) + SPX_W + INV_W + 1;
  endfunction

  // Signed skewed coordinate width, scale 2^(F+1)
  function automatic int a2_w(input int sb);
    return b_w(sb) + 2;
  endfunction

  function automatic int col_w(input int f, input int sb);
    return a2_w(sb) - f - 1;
  endfunction

  function automatic int row_w(input int f, input int sb);
    return b_w(sb) - f;
  endfunction

  // Width of the offset slot sum, always non-negative
  function automatic int u_w(input int f, input int sb);
    int c;
    int r;
    c = col_w(f, sb);
    r = row_w(f, sb) + 1;
    return ((c > r) ? c : r) + 3;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tcc_if.sv -----
// Valid/ready channel interfaces of the triangle cell classifier.
// Depends on tcc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcc_in_if;
  import tcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SCREEN_W-1:0] screen_col;
  logic [SCREEN_W-1:0] screen_row;

  modport source (output valid, output screen_col, output screen_row, input ready);
  modport sink   (input valid, input screen_col, input screen_row, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TRI_W-1:0] tri_col;
  logic signed [TRI_W-1:0] tri_row;
  logic                    up_half;
  logic [SLOT_W-1:0]       palette_slot;

  modport source (output valid, output tri_col, output tri_row, output up_half,
                  output palette_slot, input ready);
  modport sink   (input valid, input tri_col, input tri_row, input up_half,
                  input palette_slot, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcc_cfg.sv -----
// Configuration register file of the triangle cell classifier.
// Depends on tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tcc_pkg::cfg_t                       cfg_o
);
  import tcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_COL: cfg_d.origin_col = cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_ROW: cfg_d.origin_row = cfg_data_i[ORIGIN_W-1:0];
        REG_SPX_WIDTH:  cfg_d.spx_width  = cfg_data_i[SPX_W-1:0];
        REG_SPX_HEIGHT: cfg_d.spx_height = cfg_data_i[SPX_W-1:0];
        REG_INV_EDGE:   cfg_d.inv_edge   = cfg_data_i[INV_W-1:0];
        REG_INV_HEIGHT: cfg_d.inv_height = cfg_data_i[INV_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_col <= ORIGIN_W'(40);
      cfg_q.origin_row <= ORIGIN_W'(11);
      cfg_q.spx_width  <= SPX_W'(2);
      cfg_q.spx_height <= SPX_W'(4);
      cfg_q.inv_edge   <= INV_W'(4681);
      cfg_q.inv_height <= INV_W'(5405);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/tcc_ctl.sv -----
// Stage valid chain and per-stage load enables of the classifier pipeline.
// Depends on tcc_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module tcc_ctl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     out_ready_i,
  output logic [tcc_pkg::NSTG-1:0]      en_o,
  output logic                          out_valid_o
);
  import tcc_pkg::*;

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG-1:0] en;

  // A stage may load when it is empty or its word moves on this cycle
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign en_o        = en;
  assign out_valid_o = v_q[NSTG-1];

endmodule

`default_nettype wire

// ----- rtl/tcc_geom.sv -----
// Geometry datapath: origin offset, sub-pixel scale, reciprocal multiply,
// floor to grid cell and half test. Three registered stages. Uses tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_geom #(
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 10,
  parameter int COLOR_COUNT = 6
) (
  input  wire logic                                          clk_i,
  input  wire logic [tcc_pkg::NSTG-1:0]                      en_i,
  input  wire tcc_pkg::cfg_t                                 cfg_i,
  input  wire logic [tcc_pkg::SCREEN_W-1:0]                  sc_i,
  input  wire logic [tcc_pkg::SCREEN_W-1:0]                  sr_i,
  output logic [tcc_pkg::col_w(FRAC_BITS, SCREEN_BITS)-1:0]  col_o,
  output logic [tcc_pkg::row_w(FRAC_BITS, SCREEN_BITS)-1:0]  row_o,
  output logic                                               up_o,
  output logic [tcc_pkg::u_w(FRAC_BITS, SCREEN_BITS)-1:0]    u_o
);
  import tcc_pkg::*;

  localparam int SB     = eff_sb(SCREEN_BITS);
  localparam int DX_W   = SB + 1;
  localparam int PX_W   = px_w(SCREEN_BITS);
  localparam int B_W    = b_w(SCREEN_BITS);
  localparam int A2_W   = a2_w(SCREEN_BITS);
  localparam int COL_W  = col_w(FRAC_BITS, SCREEN_BITS);
  localparam int ROW_W  = row_w(FRAC_BITS, SCREEN_BITS);
  localparam int U_W    = u_w(FRAC_BITS, SCREEN_BITS);
  localparam int SUM_W  = U_W - 1;
  localparam longint HALF_RANGE = longint'(1) << (SUM_W - 1);
  // Multiple of the palette size that lifts every slot sum above zero
  localparam longint OFFSET =
    longint'(COLOR_COUNT) * ((HALF_RANGE + longint'(COLOR_COUNT) - 1) / COLOR_COUNT);

  // Stage 1: signed sub-pixel offsets
  logic signed [DX_W-1:0] dx, dy;
  logic signed [PX_W-1:0] dx_x, dy_x, sw_x, sh_x;
  logic signed [PX_W-1:0] px_q, py_q;

  always_comb begin
    dx   = signed'({1'b0, sc_i[SB-1:0]} - {1'b0, cfg_i.origin_col[SB-1:0]});
    dy   = signed'({1'b0, sr_i[SB-1:0]} - {1'b0, cfg_i.origin_row[SB-1:0]});
    dx_x = {{(PX_W-DX_W){dx[DX_W-1]}}, dx};
    dy_x = {{(PX_W-DX_W){dy[DX_W-1]}}, dy};
    sw_x = signed'({{(PX_W-SPX_W){1'b0}}, cfg_i.spx_width});
    sh_x = signed'({{(PX_W-SPX_W){1'b0}}, cfg_i.spx_height});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PX]) begin
      px_q <= dx_x * sw_x;
      py_q <= dy_x * sh_x;
    end
  end

  // Stage 2: reciprocal products, scale 2^F
  logic signed [B_W-1:0] px_b, py_b, ie_b, ih_b;
  logic signed [B_W-1:0] pe_q, b_q;

  always_comb begin
    px_b = {{(B_W-PX_W){px_q[PX_W-1]}}, px_q};
    py_b = {{(B_W-PX_W){py_q[PX_W-1]}}, py_q};
    ie_b = signed'({{(B_W-INV_W){1'b0}}, cfg_i.inv_edge});
    ih_b = signed'({{(B_W-INV_W){1'b0}}, cfg_i.inv_height});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_PROD]) begin
      pe_q <= px_b * ie_b;
      b_q  <= py_b * ih_b;
    end
  end

  // Stage 3: skew, floor, half test and offset slot sum
  logic [A2_W-1:0]        a2;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row;
  logic [FRAC_BITS+1:0]   fsum;
  logic                   up;
  logic [U_W-1:0]         u;

  always_comb begin
    // a = px/edge - b/2, held as 2a
    a2   = {pe_q[B_W-1], pe_q, 1'b0} - {{2{b_q[B_W-1]}}, b_q};
    col  = a2[A2_W-1:FRAC_BITS+1];
    row  = b_q[B_W-1:FRAC_BITS];
    fsum = {1'b0, a2[FRAC_BITS:0]} + {1'b0, b_q[FRAC_BITS-1:0], 1'b0};
    up   = fsum[FRAC_BITS+1];
    u    = {{(U_W-COL_W){col[COL_W-1]}}, col}
         + {{(U_W-ROW_W-1){row[ROW_W-1]}}, row, 1'b0}
         + {{(U_W-1){1'b0}}, up}
         + U_W'(OFFSET);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_CELL]) begin
      col_o <= col;
      row_o <= row;
      up_o  <= up;
      u_o   <= u;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcc_slot.sv -----
// Palette slot: non-negative remainder by the palette size through a
// reciprocal multiply and one correction. Two registered stages. Uses tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_slot #(
  parameter int COLOR_COUNT = 6,
  parameter int U_W         = 19
) (
  input  wire logic                          clk_i,
  input  wire logic [tcc_pkg::NSTG-1:0]      en_i,
  input  wire logic [U_W-1:0]                u_i,
  output logic [tcc_pkg::SLOT_W-1:0]         slot_o
);
  import tcc_pkg::*;

  localparam logic [U_W-1:0] CNT   = U_W'(COLOR_COUNT);
  localparam logic [U_W-1:0] RECIP = U_W'((longint'(1) << U_W) / COLOR_COUNT);

  // Stage 4: quotient estimate, low by at most one
  logic [2*U_W-1:0] prod;
  logic [U_W-1:0]   q_q, u_q;

  assign prod = {{U_W{1'b0}}, u_i} * {{U_W{1'b0}}, RECIP};

  always_ff @(posedge clk_i) begin
    if (en_i[ST_QUOT]) begin
      q_q <= prod[2*U_W-1:U_W];
      u_q <= u_i;
    end
  end

  // Stage 5: remainder and single correction
  logic [U_W-1:0] rem, rem_fix;

  always_comb begin
    rem     = u_q - q_q * CNT;
    rem_fix = (rem >= CNT) ? rem - CNT : rem;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      slot_o <= rem_fix[SLOT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iso_triangle_cell_classifier.sv -----
// Top level of the isometric triangle cell classifier.
// Depends on tcc_pkg, tcc_if, tcc_cfg, tcc_ctl, tcc_geom and tcc_slot.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | word
//  --------+-----------+-----------------------------------------------
//  in_i    | sink      | screen_col, screen_row (character position)
//  out_o   | source    | tri_col, tri_row, up_half, palette_slot
//  cfg     | write     | cfg_we_i, cfg_idx_i, cfg_data_i (six registers)
//
//  One word is accepted every cycle while in_i.ready is high; each result
//  is offered once its word has passed six registers (input register,
//  scale, reciprocal multiply, cell floor, slot quotient, output register).
//  Each stage has its own valid bit and loads when empty or draining, so
//  a stall on out_o only backs up once the pipeline is full.
//  Reset clears the valid chain and loads the default grid configuration.
module iso_triangle_cell_classifier #(
  parameter int COLOR_COUNT = 6,
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tcc_in_if.sink                              in_i,
  tcc_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tcc_pkg::*;

  localparam int COL_W  = col_w(FRAC_BITS, SCREEN_BITS);
  localparam int ROW_W  = row_w(FRAC_BITS, SCREEN_BITS);
  localparam int U_W    = u_w(FRAC_BITS, SCREEN_BITS);
  localparam int CEXT_W = ((COL_W > TRI_W) ? COL_W : TRI_W) + 1;
  localparam int REXT_W = ((ROW_W > TRI_W) ? ROW_W : TRI_W) + 1;
  localparam logic signed [CEXT_W-1:0] CMIN = CEXT_W'(TRI_MIN);
  localparam logic signed [CEXT_W-1:0] CMAX = CEXT_W'(TRI_MAX);
  localparam logic signed [REXT_W-1:0] RMIN = REXT_W'(TRI_MIN);
  localparam logic signed [REXT_W-1:0] RMAX = REXT_W'(TRI_MAX);

  cfg_t            cfg;
  logic [NSTG-1:0] en;

  tcc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tcc_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .en_o        (en),
    .out_valid_o (out_o.valid)
  );

  // Take a word whenever the input register can load
  assign in_i.ready = en[ST_IN];

  logic [SCREEN_W-1:0] sc_q, sr_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      sc_q <= in_i.screen_col;
      sr_q <= in_i.screen_row;
    end
  end

  logic [COL_W-1:0] col3;
  logic [ROW_W-1:0] row3;
  logic             up3;
  logic [U_W-1:0]   u3;

  tcc_geom #(
    .FRAC_BITS   (FRAC_BITS),
    .SCREEN_BITS (SCREEN_BITS),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_geom (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg),
    .sc_i  (sc_q),
    .sr_i  (sr_q),
    .col_o (col3),
    .row_o (row3),
    .up_o  (up3),
    .u_o   (u3)
  );

  tcc_slot #(
    .COLOR_COUNT (COLOR_COUNT),
    .U_W         (U_W)
  ) u_slot (
    .clk_i  (clk_i),
    .en_i   (en),
    .u_i    (u3),
    .slot_o (out_o.palette_slot)
  );

  // Clamp grid address to the output range; half and slot use the raw values
  logic signed [CEXT_W-1:0] col_x;
  logic signed [REXT_W-1:0] row_x;
  logic [TRI_W-1:0]         col_sat, row_sat;

  always_comb begin
    col_x = signed'({{(CEXT_W-COL_W){col3[COL_W-1]}}, col3});
    row_x = signed'({{(REXT_W-ROW_W){row3[ROW_W-1]}}, row3});
    if (col_x < CMIN) begin
      col_sat = TRI_W'(TRI_MIN);
    end else if (col_x > CMAX) begin
      col_sat = TRI_W'(TRI_MAX);
    end else begin
      col_sat = col_x[TRI_W-1:0];
    end
    if (row_x < RMIN) begin
      row_sat = TRI_W'(TRI_MIN);
    end else if (row_x > RMAX) begin
      row_sat = TRI_W'(TRI_MAX);
    end else begin
      row_sat = row_x[TRI_W-1:0];
    end
  end

  // Carry cell fields alongside the slot quotient and remainder stages
  logic [TRI_W-1:0] col4_q, row4_q, col5_q, row5_q;
  logic             up4_q, up5_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_QUOT]) begin
      col4_q <= col_sat;
      row4_q <= row_sat;
      up4_q  <= up3;
    end
    if (en[ST_OUT]) begin
      col5_q <= col4_q;
      row5_q <= row4_q;
      up5_q  <= up4_q;
    end
  end

  assign out_o.tri_col = signed'(col5_q);
  assign out_o.tri_row = signed'(row5_q);
  assign out_o.up_half = up5_q;

endmodule

`default_nettype wire
